// ----- design/vlbs_pkg.sv -----
package vlbs_pkg;

   // store geometry, fixed by the 9-bit free byte count
   localparam int STACK_BYTES = 256;
   localparam int PTR_W       = 9;
   localparam int ADDR_W      = 8;

   typedef enum logic [1:0] {
      ACT_PUSH  = 2'd0,
      ACT_POP   = 2'd1,
      ACT_PEEK  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH,
      S_READ,
      S_FINISH
   } state_type;

   typedef struct packed {
      action_type  action;
      logic [3:0]  length;
      logic [63:0] push_data;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] read_data;
      logic [3:0]  read_length;
      logic        stack_empty;
      logic [8:0]  free_bytes;
   } rsp_type;

endpackage

// ----- design/variable_length_byte_stack_unit.sv -----
// Variable-length byte stack over a byte-wide store that grows downward.
//
// Request channel (req_valid, req_stall, req_data): one transfer carries an
// action (push, pop, peek, clear), a length and up to 8 push bytes. Response
// channel (rsp_valid, rsp_stall, rsp_data): exactly one response per request
// with status, returned bytes, returned length, empty flag and free bytes.
//
// Items are handled one at a time. The store is read and written one byte
// at a time: a push writes its length header and then its item bytes, a pop
// or peek reads the header and then the bytes it allows, and clear and
// refused requests touch no store byte.
// A new request is taken as soon as the previous one has been placed in the
// response register, even while that response still waits for the receiver.
// While rsp_stall holds the response, a finished request waits in its last
// step and req_stall stays high.
// Reset empties the stack at once (free bytes 256); store contents are not
// cleared, only bytes written by a push are ever read back.
module variable_length_byte_stack_unit #(
   parameter int MAX_ITEM_BYTES = 8,
   parameter int HEADER_BYTES   = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vlbs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vlbs_pkg::rsp_type rsp_data
);

   import vlbs_pkg::*;

   localparam int CNT_W = $clog2(HEADER_BYTES + MAX_ITEM_BYTES + 1);
   localparam logic [3:0]       MAX_LEN = 4'(MAX_ITEM_BYTES);
   localparam logic [PTR_W-1:0] HDR_P   = PTR_W'(HEADER_BYTES);
   localparam logic [CNT_W-1:0] HDR_C   = CNT_W'(HEADER_BYTES);
   localparam logic [PTR_W-1:0] BASE    = PTR_W'(STACK_BYTES);

   state_type        state_ff, state_in;
   action_type       act_ff, act_in;
   logic [3:0]       len_ff, len_in;
   logic [63:0]      data_ff, data_in;
   status_type       status_ff, status_in;
   logic [PTR_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] pend_idx_ff, pend_idx_in;
   logic             pend_oob_ff, pend_oob_in;
   logic [7:0]       hdr_lo_ff, hdr_lo_in;
   logic             hdr_hi_ff, hdr_hi_in;
   logic             hdr_done_ff, hdr_done_in;
   logic [63:0]      rdd_ff, rdd_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]       wr_byte, rd_byte, cap_byte;

   logic [3:0]       len_clip, stored_w, n_w;
   logic [PTR_W-1:0] need, addr_p, room, step, top_fin;
   logic [CNT_W-1:0] lim;
   logic             issue, out_free, read_op;

   // byte-wide stack store
   vlbs_ram #(
      .WIDTH (8),
      .DEPTH (STACK_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_byte)
   );

   // length terms and pointer arithmetic
   always_comb begin
      len_clip = (req_data.length > MAX_LEN) ? MAX_LEN : req_data.length;
      need     = PTR_W'(len_clip) + HDR_P;
      stored_w = (hdr_hi_ff || (hdr_lo_ff > 8'(MAX_ITEM_BYTES))) ? MAX_LEN : hdr_lo_ff[3:0];
      n_w      = (len_ff < stored_w) ? len_ff : stored_w;
      lim      = hdr_done_ff ? (HDR_C + CNT_W'(n_w)) : HDR_C;
      addr_p   = top_ff + PTR_W'(cnt_ff);
      room     = BASE - top_ff;
      step     = HDR_P + PTR_W'(stored_w);
      read_op  = (act_ff == ACT_POP) || (act_ff == ACT_PEEK);
      cap_byte = pend_oob_ff ? 8'd0 : rd_byte;
      out_free = !rsp_valid_ff || !rsp_stall;
      issue    = (state_ff == S_READ) && (cnt_ff < lim);
   end

   // push byte: length header at the bottom, item bytes above it
   always_comb begin
      wr_byte = 8'd0;
      if (cnt_ff == '0) begin
         wr_byte = {4'd0, len_ff};
      end
      for (int k = 0; k < MAX_ITEM_BYTES; k++) begin
         if (cnt_ff == CNT_W'(HEADER_BYTES + k)) begin
            wr_byte = data_ff[8*k +: 8];
         end
      end
   end

   // sequencer: next state, store accesses and response
   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      len_in      = len_ff;
      data_in     = data_ff;
      status_in   = status_ff;
      top_in      = top_ff;
      cnt_in      = cnt_ff;
      pend_in     = issue;
      pend_idx_in = cnt_ff;
      pend_oob_in = addr_p[PTR_W-1];
      hdr_lo_in   = hdr_lo_ff;
      hdr_hi_in   = hdr_hi_ff;
      hdr_done_in = hdr_done_ff;
      rdd_in      = rdd_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en       = 1'b0;
      wr_addr     = addr_p[ADDR_W-1:0];
      rd_en       = issue && !addr_p[PTR_W-1];
      rd_addr     = addr_p[ADDR_W-1:0];
      top_fin     = top_ff;

      // capture a byte read in the previous cycle
      if (pend_ff) begin
         if (pend_idx_ff == '0) begin
            hdr_lo_in = cap_byte;
         end else if ((pend_idx_ff < HDR_C) && (cap_byte != 8'd0)) begin
            hdr_hi_in = 1'b1;
         end
         if (pend_idx_ff == HDR_C - CNT_W'(1)) begin
            hdr_done_in = 1'b1;
         end
         for (int k = 0; k < MAX_ITEM_BYTES; k++) begin
            if (pend_idx_ff == CNT_W'(HEADER_BYTES + k)) begin
               rdd_in[8*k +: 8] = cap_byte;
            end
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in      = req_data.action;
               data_in     = req_data.push_data;
               len_in      = req_data.length;
               cnt_in      = '0;
               hdr_lo_in   = 8'd0;
               hdr_hi_in   = 1'b0;
               hdr_done_in = 1'b0;
               rdd_in      = 64'd0;
               status_in   = ST_DONE;
               unique case (req_data.action)
                  ACT_PUSH: begin
                     len_in = len_clip;
                     if (top_ff < need) begin
                        status_in = ST_FULL;
                        state_in  = S_FINISH;
                     end else begin
                        top_in   = top_ff - need;
                        state_in = S_PUSH;
                     end
                  end
                  ACT_POP, ACT_PEEK: begin
                     if (top_ff >= BASE) begin
                        status_in = ST_EMPTY;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  ACT_CLEAR: begin
                     top_in   = BASE;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_PUSH: begin
            // one byte per cycle from the new top upward
            wr_en  = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == HDR_C + CNT_W'(len_ff) - CNT_W'(1)) begin
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            // header first, then the bytes it allows
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (hdr_done_ff && !pend_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if ((act_ff == ACT_POP) && (status_ff == ST_DONE)) begin
               top_fin = (step >= room) ? BASE : (top_ff + step);
            end
            // hold until the response register is free
            if (out_free) begin
               rsp_in.status      = status_ff;
               rsp_in.read_data   = rdd_ff;
               rsp_in.read_length = (read_op && (status_ff == ST_DONE)) ? n_w : 4'd0;
               rsp_in.stack_empty = (top_fin >= BASE);
               rsp_in.free_bytes  = top_fin;
               rsp_valid_in       = 1'b1;
               top_in             = top_fin;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= BASE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      len_ff      <= len_in;
      data_ff     <= data_in;
      status_ff   <= status_in;
      cnt_ff      <= cnt_in;
      pend_idx_ff <= pend_idx_in;
      pend_oob_ff <= pend_oob_in;
      hdr_lo_ff   <= hdr_lo_in;
      hdr_hi_ff   <= hdr_hi_in;
      hdr_done_ff <= hdr_done_in;
      rdd_ff      <= rdd_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/vlbs_ram.sv -----
module vlbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/tb_variable_length_byte_stack_unit.sv -----
module tb_variable_length_byte_stack_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import vlbs_pkg::*;

   localparam int unsigned MAX_ITEM_BYTES = 8;
   localparam int unsigned HEADER_BYTES   = 4;
   localparam int unsigned CYCLE_LIMIT    = 1000000;
   localparam int unsigned PRINT_LIMIT    = 40;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the stack
   logic [7:0]  shadow_bytes [STACK_BYTES];
   int unsigned shadow_top;

   rsp_type     pending_rsp_q [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned rsp_hold_left  = 0;
   bit          req_gaps_on    = 1'b1;
   bit          rsp_stalls_on  = 1'b1;

   variable_length_byte_stack_unit #(
      .MAX_ITEM_BYTES(MAX_ITEM_BYTES),
      .HEADER_BYTES  (HEADER_BYTES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] shadow_read(input int unsigned addr);
      if (addr < STACK_BYTES) return shadow_bytes[addr];
      return 8'h00;
   endfunction

   // apply one request to the shadow stack and return the response it causes
   function automatic rsp_type predict_stack_op(input req_type item);
      rsp_type     res;
      int unsigned len, stored, n, room, span, i;
      res = '0;
      res.status = ST_DONE;
      case (item.action)
         ACT_PUSH: begin
            len = (item.length > MAX_ITEM_BYTES) ? MAX_ITEM_BYTES : item.length;
            if (shadow_top < len + HEADER_BYTES) begin
               res.status = ST_FULL;
            end else begin
               // data bytes above, length header below
               shadow_top = shadow_top - len;
               for (i = 0; i < len; i++)
                  shadow_bytes[shadow_top + i] = item.push_data[8*i +: 8];
               shadow_top = shadow_top - HEADER_BYTES;
               for (i = 0; i < HEADER_BYTES; i++)
                  shadow_bytes[shadow_top + i] = 8'(len >> (8 * i));
            end
         end
         ACT_POP, ACT_PEEK: begin
            if (shadow_top >= STACK_BYTES) begin
               res.status = ST_EMPTY;
            end else begin
               stored = 0;
               for (i = 0; i < HEADER_BYTES; i++)
                  stored |= 32'(shadow_read(shadow_top + i)) << (8 * i);
               if (stored > MAX_ITEM_BYTES) stored = MAX_ITEM_BYTES;
               n = (item.length < stored) ? item.length : stored;
               res.read_length = 4'(n);
               for (i = 0; i < n; i++)
                  res.read_data[8*i +: 8] = shadow_read(shadow_top + HEADER_BYTES + i);
               if (item.action == ACT_POP) begin
                  // saturate at the base
                  room = STACK_BYTES - shadow_top;
                  span = HEADER_BYTES + stored;
                  shadow_top = (span >= room) ? STACK_BYTES : shadow_top + span;
               end
            end
         end
         default: begin
            shadow_top = STACK_BYTES;
         end
      endcase
      res.stack_empty = (shadow_top >= STACK_BYTES);
      res.free_bytes  = 9'(shadow_top);
      return res;
   endfunction

   function automatic req_type make_request(input action_type act, input int unsigned len,
                                            input logic [63:0] data);
      req_type item;
      item.action    = act;
      item.length    = 4'(len);
      item.push_data = data;
      return item;
   endfunction

   function automatic logic [63:0] random_bytes();
      return {$urandom(), $urandom()};
   endfunction

   function automatic int unsigned random_length();
      if ($urandom_range(0, 6) != 0) return $urandom_range(0, MAX_ITEM_BYTES);
      return $urandom_range(MAX_ITEM_BYTES + 1, 15);
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch on %s at cycle %0d: expected %h, got %h",
                  field, cycle_count, want, got);
   endtask

   // one request transfer, with a random gap ahead of it while gaps are on
   task automatic send_request(input req_type item);
      int unsigned gap;
      gap = req_gaps_on ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp_q.push_back(predict_stack_op(item));
   endtask

   // hold the request side until every response has come back
   task automatic wait_all_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   // stall the response side at random while stalls are on
   always @(negedge clock) begin
      if (!rsp_stalls_on) begin
         rsp_hold_left = 0;
         rsp_stall <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_hold_left = pick_gap();
         rsp_stall <= (rsp_hold_left != 0);
         if (rsp_hold_left != 0) rsp_hold_left--;
      end
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("response with none pending", '0, 64'(rsp_data.status));
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(want.status), 64'(rsp_data.status));
            if (rsp_data.read_data !== want.read_data)
               report_mismatch("read_data", want.read_data, rsp_data.read_data);
            if (rsp_data.read_length !== want.read_length)
               report_mismatch("read_length", 64'(want.read_length), 64'(rsp_data.read_length));
            if (rsp_data.stack_empty !== want.stack_empty)
               report_mismatch("stack_empty", 64'(want.stack_empty), 64'(rsp_data.stack_empty));
            if (rsp_data.free_bytes !== want.free_bytes)
               report_mismatch("free_bytes", 64'(want.free_bytes), 64'(rsp_data.free_bytes));
         end
      end
   end

   // reads and clear on an empty stack
   task automatic test_empty_reads();
      send_request(make_request(ACT_POP, MAX_ITEM_BYTES, random_bytes()));
      send_request(make_request(ACT_PEEK, 0, random_bytes()));
      send_request(make_request(ACT_PEEK, 15, random_bytes()));
      send_request(make_request(ACT_CLEAR, 15, random_bytes()));
   endtask

   // field extremes, saturation, short reads and clear
   task automatic test_basic_items();
      send_request(make_request(ACT_PUSH, 0, random_bytes()));
      send_request(make_request(ACT_PEEK, MAX_ITEM_BYTES, random_bytes()));
      send_request(make_request(ACT_POP, 0, '0));
      send_request(make_request(ACT_PUSH, MAX_ITEM_BYTES, '1));
      send_request(make_request(ACT_PUSH, 3, '0));
      send_request(make_request(ACT_PEEK, 15, '1));
      send_request(make_request(ACT_POP, 2, '0));
      send_request(make_request(ACT_PEEK, 0, '0));
      send_request(make_request(ACT_POP, MAX_ITEM_BYTES, '0));
      send_request(make_request(ACT_PUSH, 15, '1));
      send_request(make_request(ACT_PUSH, 9, random_bytes()));
      send_request(make_request(ACT_PEEK, 5, '0));
      send_request(make_request(ACT_POP, 15, '0));
      send_request(make_request(ACT_POP, MAX_ITEM_BYTES, '0));
      send_request(make_request(ACT_PUSH, 5, random_bytes()));
      send_request(make_request(ACT_PUSH, 1, random_bytes()));
      send_request(make_request(ACT_CLEAR, 0, '0));
      send_request(make_request(ACT_PEEK, MAX_ITEM_BYTES, '0));
   endtask

   // fill the store to zero free bytes, hit full, then drain past empty
   task automatic test_fill_and_drain();
      int unsigned k;
      for (k = 0; k < 21; k++)
         send_request(make_request(ACT_PUSH, MAX_ITEM_BYTES, random_bytes()));
      send_request(make_request(ACT_PUSH, 12, random_bytes()));
      send_request(make_request(ACT_PUSH, 1, random_bytes()));
      send_request(make_request(ACT_PUSH, 0, random_bytes()));
      send_request(make_request(ACT_PUSH, 0, random_bytes()));
      send_request(make_request(ACT_PEEK, MAX_ITEM_BYTES, '0));
      wait_all_results();
      for (k = 0; k < 24; k++)
         send_request(make_request(ACT_POP, random_length(), '0));
      wait_all_results();
   endtask

   // random operations in phases that lean toward filling or draining
   task automatic test_random_mix(input int unsigned count);
      req_type     item;
      int unsigned k, r, push_pct;
      push_pct = 50;
      for (k = 0; k < count; k++) begin
         if (k % 100 == 0) begin
            r = $urandom_range(0, 3);
            push_pct = (r == 0) ? 80 : (r == 1) ? 20 : 50;
            req_gaps_on   = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
         end
         if (k % 250 == 125) wait_all_results();
         r = $urandom_range(0, 99);
         if (r < 2)
            item = make_request(ACT_CLEAR, random_length(), random_bytes());
         else if (r < 2 + push_pct)
            item = make_request(ACT_PUSH, random_length(), random_bytes());
         else if ($urandom_range(0, 4) < 3)
            item = make_request(ACT_POP, random_length(), random_bytes());
         else
            item = make_request(ACT_PEEK, random_length(), random_bytes());
         send_request(item);
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      shadow_top = STACK_BYTES;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_reads();
      test_basic_items();
      wait_all_results();
      test_fill_and_drain();
      test_random_mix(1500);

      // drain, then watch for stray responses
      wait_all_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
